FILE: sv/rar_pkg.sv
// ----------------------------------------------------------------------------
// rar_pkg: shared types and constants of the rational reduce core
// Field widths, operation codes, sequencer states and beat structs.
// ----------------------------------------------------------------------------
package rar_pkg;

  localparam int IN_WIDTH = 16;
  localparam int MAG_W    = 2 * IN_WIDTH;   // magnitude of any raw part
  localparam int SUM_W    = MAG_W + 1;      // signed raw part
  localparam int NUM_W    = 33;
  localparam int DEN_W    = 31;

  localparam logic [1:0] KIND_REDUCE = 2'd0;
  localparam logic [1:0] KIND_ADD    = 2'd1;
  localparam logic [1:0] KIND_MUL    = 2'd2;

  typedef struct packed {
    logic [1:0]                 kind;
    logic signed [IN_WIDTH-1:0] a_num;
    logic signed [IN_WIDTH-1:0] a_den;
    logic signed [IN_WIDTH-1:0] b_num;
    logic signed [IN_WIDTH-1:0] b_den;
  } rar_in_t;

  typedef struct packed {
    logic signed [NUM_W-1:0] res_num;
    logic [DEN_W-1:0]        res_den;
    logic                    div_error;
  } rar_out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL0,
    S_MUL1,
    S_MUL2,
    S_PREP,
    S_GCD,
    S_DIVN,
    S_DIVD,
    S_FIN
  } rar_state_t;

endpackage

FILE: sv/rar_mul.sv
// ----------------------------------------------------------------------------
// rar_mul: registered signed multiplier
// One product of two input-width operands per cycle, result in the next cycle.
// ----------------------------------------------------------------------------
module rar_mul
  import rar_pkg::*;
(
  input  logic                       clk,
  input  logic signed [IN_WIDTH-1:0] x,
  input  logic signed [IN_WIDTH-1:0] y,
  output logic signed [MAG_W-1:0]    p
);

  always_ff @(posedge clk) begin
    p <= x * y;
  end

endmodule

FILE: sv/rar_gcd.sv
// ----------------------------------------------------------------------------
// rar_gcd: iterative binary GCD
// One shift or subtract step per cycle on two nonzero magnitudes.
// ----------------------------------------------------------------------------
module rar_gcd
  import rar_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [MAG_W-1:0] a,
  input  logic [MAG_W-1:0] b,
  output logic             done,
  output logic [MAG_W-1:0] g
);

  localparam int K_W = $clog2(MAG_W);

  logic             run;
  logic [MAG_W-1:0] u;
  logic [MAG_W-1:0] v;
  logic [K_W-1:0]   k;
  logic             u_big;
  logic [MAG_W-1:0] diff;
  logic             finish;

  // single shared subtractor: larger minus smaller
  assign u_big  = (u > v);
  assign diff   = u_big ? (u - v) : (v - u);
  assign finish = run && (u[0] || v[0]) && (u == v);

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= finish;
      if (start) begin
        run <= 1'b1;
      end else if (finish) begin
        run <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      u <= a;
      v <= b;
      k <= '0;
    end else if (run) begin
      if (!u[0] && !v[0]) begin
        // strip a common factor of two
        u <= u >> 1;
        v <= v >> 1;
        k <= k + K_W'(1);
      end else if (u == v) begin
        g <= u << k;
      end else if (!u[0]) begin
        u <= u >> 1;
      end else if (!v[0]) begin
        v <= v >> 1;
      end else if (u_big) begin
        u <= diff >> 1;
      end else begin
        v <= diff >> 1;
      end
    end
  end

endmodule

FILE: sv/rar_div.sv
// ----------------------------------------------------------------------------
// rar_div: iterative restoring divider
// One quotient bit per cycle; the remainder is dropped.
// ----------------------------------------------------------------------------
module rar_div
  import rar_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [MAG_W-1:0] dividend,
  input  logic [MAG_W-1:0] divisor,
  output logic             done,
  output logic [MAG_W-1:0] quo
);

  localparam int C_W = $clog2(MAG_W);
  localparam logic [C_W-1:0] LAST = C_W'(MAG_W - 1);

  logic             run;
  logic [C_W-1:0]   cnt;
  logic [MAG_W-1:0] rem;
  logic [MAG_W-1:0] dsr;
  logic [MAG_W:0]   shifted;
  logic [MAG_W:0]   trial;
  logic             fits;

  assign shifted = {rem, quo[MAG_W-1]};
  assign trial   = shifted - {1'b0, dsr};
  assign fits    = (shifted >= {1'b0, dsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + C_W'(1);
        if (cnt == LAST) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dsr <= divisor;
    end else if (run) begin
      rem <= fits ? trial[MAG_W-1:0] : shifted[MAG_W-1:0];
      quo <= {quo[MAG_W-2:0], fits};
    end
  end

endmodule

FILE: sv/rational_arith_reduce_core.sv
// ----------------------------------------------------------------------------
// rational_arith_reduce_core: add / multiply signed fractions in lowest terms
// Reduces, adds or multiplies two signed fractions and returns the result
// reduced by its GCD with a positive denominator.
// ----------------------------------------------------------------------------
// Usage: raise start with an item while busy is low; the item is taken at
// that edge and busy stays high until the result goes out. The result beat
// sits on result for exactly one cycle with done high and cannot be held
// off, so the receiver must take it then. A zero numerator or zero
// denominator skips the GCD unit and the divider; otherwise the cost is set
// by the binary GCD unit (one shift or subtract per cycle on the 32-bit raw
// magnitudes) and by the restoring divider, which runs twice per item at one
// quotient bit a cycle. The shared multiplier gives three products before
// the raw numerator and denominator are formed. A zero numerator returns
// 0/1; a zero denominator under a nonzero numerator returns 0/1 with
// div_error.
// ----------------------------------------------------------------------------
module rational_arith_reduce_core
  import rar_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  rar_in_t  item,
  output logic     busy,
  output logic     done,
  output rar_out_t result
);

  rar_state_t state;
  rar_state_t state_next;

  rar_in_t                 item_q;
  logic signed [MAG_W-1:0] t0;        // first product
  logic signed [MAG_W-1:0] t1;        // second product
  logic [MAG_W-1:0]        mn;        // raw numerator magnitude
  logic [MAG_W-1:0]        md;        // raw denominator magnitude
  logic                    neg;
  logic [MAG_W-1:0]        qn;        // reduced numerator magnitude

  // multiplier operands and product
  logic signed [IN_WIDTH-1:0] mx;
  logic signed [IN_WIDTH-1:0] my;
  logic signed [MAG_W-1:0]    prod;

  // raw fraction formed in the prep cycle
  logic signed [SUM_W-1:0] raw_n;
  logic signed [SUM_W-1:0] raw_d;
  logic [MAG_W-1:0]        mag_n;
  logic [MAG_W-1:0]        mag_d;
  logic                    same_den;
  logic                    n_zero;
  logic                    d_zero;

  // sequencer controls
  logic             accept;
  logic             gcd_start;
  logic             gcd_done;
  logic [MAG_W-1:0] gcd_g;
  logic             div_start;
  logic             div_done;
  logic [MAG_W-1:0] div_dividend;
  logic [MAG_W-1:0] quo;
  logic             load_res;
  rar_out_t         res_next;
  logic [NUM_W-1:0] num_mag;

  assign accept = start && !busy;

  // ---------------------------------------------------------------- units
  rar_mul u_mul (
    .clk (clk),
    .x   (mx),
    .y   (my),
    .p   (prod)
  );

  rar_gcd u_gcd (
    .clk   (clk),
    .rst   (rst),
    .start (gcd_start),
    .a     (mag_n),
    .b     (mag_d),
    .done  (gcd_done),
    .g     (gcd_g)
  );

  // the divider divides by the GCD, which holds once the GCD unit is done
  rar_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (gcd_g),
    .done     (div_done),
    .quo      (quo)
  );

  // ------------------------------------------------------ multiplier feed
  // MUL0: first product (a_num * b_den for add, a_num * b_num for multiply)
  // MUL1: b_num * a_den, MUL2: a_den * b_den; each lands in the next cycle.
  always_comb begin
    mx = item_q.a_den;
    my = item_q.b_den;
    unique case (state)
      S_MUL0: begin
        mx = item_q.a_num;
        my = (item_q.kind == KIND_MUL) ? item_q.b_num : item_q.b_den;
      end
      S_MUL1: begin
        mx = item_q.b_num;
        my = item_q.a_den;
      end
      default: begin
        mx = item_q.a_den;
        my = item_q.b_den;
      end
    endcase
  end

  // ------------------------------------------------------ raw fraction
  // Equal denominators in an add keep the common denominator; this matters
  // when both are zero, where the numerator sum decides the error flag.
  assign same_den = (item_q.a_den == item_q.b_den);

  always_comb begin
    case (item_q.kind)
      KIND_ADD: begin
        if (same_den) begin
          raw_n = SUM_W'(item_q.a_num) + SUM_W'(item_q.b_num);
          raw_d = SUM_W'(item_q.a_den);
        end else begin
          raw_n = SUM_W'(t0) + SUM_W'(t1);
          raw_d = SUM_W'(prod);
        end
      end
      KIND_MUL: begin
        raw_n = SUM_W'(t0);
        raw_d = SUM_W'(prod);
      end
      default: begin
        raw_n = SUM_W'(item_q.a_num);
        raw_d = SUM_W'(item_q.a_den);
      end
    endcase
  end

  assign mag_n  = raw_n[SUM_W-1] ? MAG_W'(-raw_n) : MAG_W'(raw_n);
  assign mag_d  = raw_d[SUM_W-1] ? MAG_W'(-raw_d) : MAG_W'(raw_d);
  assign n_zero = (raw_n == '0);
  assign d_zero = (raw_d == '0);

  // ------------------------------------------------------ sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_MUL0;
        end
      end
      S_MUL0: state_next = S_MUL1;
      S_MUL1: state_next = S_MUL2;
      S_MUL2: state_next = S_PREP;
      S_PREP: begin
        state_next = (n_zero || d_zero) ? S_FIN : S_GCD;
      end
      S_GCD: begin
        if (gcd_done) begin
          state_next = S_DIVN;
        end
      end
      S_DIVN: begin
        if (div_done) begin
          state_next = S_DIVD;
        end
      end
      S_DIVD: begin
        if (div_done) begin
          state_next = S_FIN;
        end
      end
      S_FIN: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    busy         = 1'b1;
    done         = 1'b0;
    gcd_start    = 1'b0;
    div_start    = 1'b0;
    div_dividend = mn;
    load_res     = 1'b0;
    unique case (state)
      S_IDLE: busy = 1'b0;
      S_PREP: begin
        gcd_start = !(n_zero || d_zero);
        load_res  = n_zero || d_zero;
      end
      S_GCD: begin
        div_start    = gcd_done;
        div_dividend = mn;
      end
      S_DIVN: begin
        div_start    = div_done;
        div_dividend = md;
      end
      S_DIVD: load_res = div_done;
      S_FIN:  done = 1'b1;
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  // ------------------------------------------------------ datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      item_q <= item;
    end
    if (state == S_MUL1) begin
      t0 <= prod;
    end
    if (state == S_MUL2) begin
      t1 <= prod;
    end
    if (state == S_PREP) begin
      mn  <= mag_n;
      md  <= mag_d;
      neg <= raw_n[SUM_W-1] ^ raw_d[SUM_W-1];
    end
    if (state == S_DIVN && div_done) begin
      qn <= quo;
    end
    if (load_res) begin
      result <= res_next;
    end
  end

  // ------------------------------------------------------ result beat
  // Zero cases give 0/1; flag the error when only the denominator is zero.
  // Otherwise put the sign on the numerator; the denominator is the second
  // quotient, which is on the divider output when the reduced beat loads.
  assign num_mag = NUM_W'(qn);

  always_comb begin
    if (state == S_PREP) begin
      res_next.res_num   = '0;
      res_next.res_den   = DEN_W'(1);
      res_next.div_error = !n_zero;
    end else begin
      res_next.res_num   = neg ? -num_mag : num_mag;
      res_next.res_den   = DEN_W'(quo);
      res_next.div_error = 1'b0;
    end
  end

endmodule
